// ===== rtl/wsm_pkg.sv =====
// Shared types, codes and the frame fold function for the WAV to mono PCM parser.
package wsm_pkg;

  typedef enum logic [1:0] {
    KIND_SAMPLE = 2'd0,
    KIND_INFO   = 2'd1,
    KIND_FINISH = 2'd2,
    KIND_ERROR  = 2'd3
  } kind_t;

  localparam logic [3:0] ERR_NONE       = 4'd0;
  localparam logic [3:0] ERR_SHORT      = 4'd1;
  localparam logic [3:0] ERR_NO_RIFF    = 4'd2;
  localparam logic [3:0] ERR_NO_WAVE    = 4'd3;
  localparam logic [3:0] ERR_SMALL_FMT  = 4'd4;
  localparam logic [3:0] ERR_DATA_EARLY = 4'd5;
  localparam logic [3:0] ERR_NO_DATA    = 4'd6;
  localparam logic [3:0] ERR_NOT_PCM    = 4'd7;
  localparam logic [3:0] ERR_ZERO_ALIGN = 4'd8;

  localparam logic [31:0] WORD_RIFF = 32'h4646_4952;
  localparam logic [31:0] WORD_WAVE = 32'h4556_4157;
  localparam logic [31:0] WORD_FMT  = 32'h2074_6D66;
  localparam logic [31:0] WORD_DATA = 32'h6174_6164;
  localparam logic [5:0]  MIN_BYTES = 6'd44;
  localparam logic [15:0] FMT_BODY  = 16'd16;
  localparam logic [7:0]  BIAS_8BIT = 8'd128;

  typedef struct packed {
    kind_t              kind;
    logic signed [15:0] sample;
    logic [3:0]         err;
    logic [31:0]        rate;
    logic [15:0]        chans;
    logic [15:0]        bits;
    logic               last;
  } res_t;

  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } push_t;

  function automatic logic [15:0] fold_frame(input logic [3:0][7:0] fb,
                                             input logic [15:0] chans,
                                             input logic [15:0] bits);
    logic signed [16:0] s;
    logic [8:0]         sum8;
    logic [7:0]         a;
    logic [15:0]        r;
    s    = $signed({fb[1][7], fb[1], fb[0]}) + $signed({fb[3][7], fb[3], fb[2]});
    sum8 = {1'b0, fb[0]} + {1'b0, fb[1]};
    a    = (chans >= 16'd2) ? sum8[8:1] : fb[0];
    if (bits == 16'd16) begin
      r = (chans >= 16'd2) ? s[16:1] : {fb[1], fb[0]};
    end else begin
      r = {a - BIAS_8BIT, 8'h00};
    end
    return r;
  endfunction

endpackage

// ===== rtl/wsm_parser.sv =====
// Byte-serial RIFF/WAVE chunk parser; updates state and produces up to two results per byte.
module wsm_parser import wsm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       fire,
  input  logic [7:0] byte_value,
  input  logic       last_byte,
  output push_t      push
);

  typedef enum logic [6:0] {
    PH_HEADER = 7'b0000001,
    PH_CHUNK  = 7'b0000010,
    PH_FMT    = 7'b0000100,
    PH_SKIP   = 7'b0001000,
    PH_DATA   = 7'b0010000,
    PH_WAIT   = 7'b0100000,
    PH_DONE   = 7'b1000000
  } phase_t;

  typedef enum logic [1:0] {
    CK_OTHER = 2'd0,
    CK_FMT   = 2'd1,
    CK_DATA  = 2'd2
  } ckind_t;

  phase_t          phase_r, phase_nxt;
  logic [5:0]      bc_r, bc_nxt;
  logic [31:0]     fs_r, fs_nxt;
  logic [32:0]     rem_r, rem_nxt;
  ckind_t          ckind_r, ckind_nxt;
  logic            have_fmt_r, have_fmt_nxt;
  logic [15:0]     tag_r, tag_nxt;
  logic [15:0]     chans_r, chans_nxt;
  logic [31:0]     rate_r, rate_nxt;
  logic [15:0]     align_r, align_nxt;
  logic [15:0]     bits_r, bits_nxt;
  logic [15:0]     fbc_r, fbc_nxt;
  logic [3:0][7:0] fb_r, fb_nxt;
  logic [3:0]      pend_r, pend_nxt;

  logic        raise_en;
  logic [3:0]  raise_code;
  logic        e_info, e_sample, e_fin, e_err;
  logic [3:0]  err_code;
  logic [15:0] sample;
  logic [15:0] k;
  logic [32:0] size_pad;
  res_t        rs0, rs1, rx;
  logic [1:0]  n;

  always_comb begin
    phase_nxt    = phase_r;
    bc_nxt       = bc_r;
    fs_nxt       = fs_r;
    rem_nxt      = rem_r;
    ckind_nxt    = ckind_r;
    have_fmt_nxt = have_fmt_r;
    tag_nxt      = tag_r;
    chans_nxt    = chans_r;
    rate_nxt     = rate_r;
    align_nxt    = align_r;
    bits_nxt     = bits_r;
    fbc_nxt      = fbc_r;
    fb_nxt       = fb_r;
    pend_nxt     = pend_r;
    raise_en     = 1'b0;
    raise_code   = ERR_NONE;
    e_info       = 1'b0;
    e_sample     = 1'b0;
    e_fin        = 1'b0;
    e_err        = 1'b0;
    err_code     = ERR_NONE;
    sample       = 16'd0;
    k            = fbc_r;
    size_pad     = 33'd0;

    if (fire && phase_r != PH_DONE) begin
      if (bc_r < MIN_BYTES) begin
        bc_nxt = bc_r + 6'd1;
      end
      unique case (phase_r)
        PH_HEADER: begin
          fs_nxt = {byte_value, fs_r[31:8]};
          if (bc_r == 6'd3 && fs_nxt != WORD_RIFF) begin
            raise_en   = 1'b1;
            raise_code = ERR_NO_RIFF;
          end else if (bc_r == 6'd11) begin
            if (fs_nxt != WORD_WAVE) begin
              raise_en   = 1'b1;
              raise_code = ERR_NO_WAVE;
            end else begin
              phase_nxt = PH_CHUNK;
              fbc_nxt   = 16'd0;
            end
          end
        end
        PH_CHUNK: begin
          fs_nxt  = {byte_value, fs_r[31:8]};
          fbc_nxt = fbc_r + 16'd1;
          size_pad = {1'b0, fs_nxt} + {32'd0, fs_nxt[0]};
          if (fbc_nxt == 16'd4) begin
            ckind_nxt = (fs_nxt == WORD_FMT)  ? CK_FMT :
                        (fs_nxt == WORD_DATA) ? CK_DATA : CK_OTHER;
          end else if (fbc_nxt >= 16'd8) begin
            fbc_nxt = 16'd0;
            if (ckind_r == CK_FMT) begin
              if (fs_nxt < {16'd0, FMT_BODY}) begin
                raise_en   = 1'b1;
                raise_code = ERR_SMALL_FMT;
              end else begin
                have_fmt_nxt = 1'b1;
                rem_nxt      = size_pad;
                phase_nxt    = PH_FMT;
              end
            end else if (ckind_r == CK_DATA) begin
              if (!have_fmt_r) begin
                raise_en   = 1'b1;
                raise_code = ERR_DATA_EARLY;
              end else if (tag_r != 16'd1) begin
                raise_en   = 1'b1;
                raise_code = ERR_NOT_PCM;
              end else if (align_r == 16'd0) begin
                raise_en   = 1'b1;
                raise_code = ERR_ZERO_ALIGN;
              end else begin
                e_info    = 1'b1;
                rem_nxt   = {1'b0, fs_nxt};
                fb_nxt    = '0;
                phase_nxt = PH_DATA;
                if (fs_nxt == 32'd0 || last_byte) begin
                  e_fin     = 1'b1;
                  phase_nxt = PH_DONE;
                end
              end
            end else begin
              rem_nxt   = size_pad;
              phase_nxt = (size_pad == 33'd0) ? PH_CHUNK : PH_SKIP;
            end
          end
        end
        PH_FMT: begin
          if (k < 16'd2) begin
            if (k[0]) tag_nxt[15:8] = byte_value;
            else      tag_nxt[7:0]  = byte_value;
          end else if (k < 16'd4) begin
            if (k[0]) chans_nxt[15:8] = byte_value;
            else      chans_nxt[7:0]  = byte_value;
          end else if (k < 16'd8) begin
            rate_nxt[k[1:0]*8 +: 8] = byte_value;
          end else if (k >= 16'd12 && k < 16'd14) begin
            if (k[0]) align_nxt[15:8] = byte_value;
            else      align_nxt[7:0]  = byte_value;
          end else if (k >= 16'd14 && k < 16'd16) begin
            if (k[0]) bits_nxt[15:8] = byte_value;
            else      bits_nxt[7:0]  = byte_value;
          end
          fbc_nxt = k + 16'd1;
          rem_nxt = rem_r - 33'd1;
          if (fbc_nxt >= FMT_BODY) begin
            fbc_nxt   = 16'd0;
            phase_nxt = (rem_nxt == 33'd0) ? PH_CHUNK : PH_SKIP;
          end
        end
        PH_SKIP: begin
          rem_nxt = rem_r - 33'd1;
          if (rem_nxt == 33'd0) begin
            fbc_nxt   = 16'd0;
            phase_nxt = PH_CHUNK;
          end
        end
        PH_DATA: begin
          if (fbc_r < 16'd4) begin
            fb_nxt[fbc_r[1:0]] = byte_value;
          end
          fbc_nxt = fbc_r + 16'd1;
          rem_nxt = rem_r - 33'd1;
          if (fbc_nxt == align_r) begin
            e_sample = 1'b1;
            sample   = fold_frame(fb_nxt, chans_r, bits_r);
            fbc_nxt  = 16'd0;
            fb_nxt   = '0;
          end
          if (rem_nxt == 33'd0 || last_byte) begin
            e_fin     = 1'b1;
            phase_nxt = PH_DONE;
          end
        end
        PH_WAIT: begin
        end
        default: begin
        end
      endcase

      if (raise_en) begin
        if (bc_nxt < MIN_BYTES) begin
          if (pend_r == ERR_NONE) begin
            pend_nxt = raise_code;
          end
          phase_nxt = PH_WAIT;
        end else begin
          e_err     = 1'b1;
          err_code  = raise_code;
          phase_nxt = PH_DONE;
        end
      end

      if (phase_nxt == PH_WAIT && bc_nxt >= MIN_BYTES) begin
        e_err     = 1'b1;
        err_code  = pend_nxt;
        phase_nxt = PH_DONE;
      end else if (last_byte && phase_nxt != PH_DONE) begin
        if (bc_nxt < MIN_BYTES) begin
          e_err    = 1'b1;
          err_code = ERR_SHORT;
        end else if (phase_nxt == PH_DATA) begin
          e_fin = 1'b1;
        end else begin
          e_err    = 1'b1;
          err_code = ERR_NO_DATA;
        end
        phase_nxt = PH_DONE;
      end
    end
  end

  always_comb begin
    rs0 = '0;
    rs1 = '0;
    n   = 2'd0;
    rx  = '0;
    if (e_info) begin
      rx       = '0;
      rx.kind  = KIND_INFO;
      rx.rate  = rate_r;
      rx.chans = chans_r;
      rx.bits  = bits_r;
      if (n == 2'd0) rs0 = rx;
      else           rs1 = rx;
      n = n + 2'd1;
    end
    if (e_sample) begin
      rx        = '0;
      rx.kind   = KIND_SAMPLE;
      rx.sample = sample;
      if (n == 2'd0) rs0 = rx;
      else           rs1 = rx;
      n = n + 2'd1;
    end
    if (e_fin) begin
      rx      = '0;
      rx.kind = KIND_FINISH;
      if (n == 2'd0) rs0 = rx;
      else           rs1 = rx;
      n = n + 2'd1;
    end
    if (e_err) begin
      rx      = '0;
      rx.kind = KIND_ERROR;
      rx.err  = err_code;
      if (n == 2'd0) rs0 = rx;
      else           rs1 = rx;
      n = n + 2'd1;
    end
    if (n == 2'd1) rs0.last = 1'b1;
    if (n == 2'd2) rs1.last = 1'b1;
    push.cnt = n;
    push.r0  = rs0;
    push.r1  = rs1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HEADER;
      bc_r       <= '0;
      fs_r       <= '0;
      rem_r      <= '0;
      ckind_r    <= CK_OTHER;
      have_fmt_r <= 1'b0;
      tag_r      <= '0;
      chans_r    <= '0;
      rate_r     <= '0;
      align_r    <= '0;
      bits_r     <= '0;
      fbc_r      <= '0;
      pend_r     <= ERR_NONE;
    end else begin
      phase_r    <= phase_nxt;
      bc_r       <= bc_nxt;
      fs_r       <= fs_nxt;
      rem_r      <= rem_nxt;
      ckind_r    <= ckind_nxt;
      have_fmt_r <= have_fmt_nxt;
      tag_r      <= tag_nxt;
      chans_r    <= chans_nxt;
      rate_r     <= rate_nxt;
      align_r    <= align_nxt;
      bits_r     <= bits_nxt;
      fbc_r      <= fbc_nxt;
      pend_r     <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fb_r <= fb_nxt;
  end

endmodule

// ===== rtl/wsm_res_fifo.sv =====
// Four-entry result queue taking up to two results per cycle and giving one per transfer.
module wsm_res_fifo import wsm_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  push_t push,
  output logic  room,
  output logic  out_valid,
  input  logic  out_ready,
  output res_t  head
);

  res_t       mem_r [4];
  logic [1:0] wr_r, wr_nxt;
  logic [1:0] rd_r, rd_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic       pop;

  assign out_valid = (cnt_r != 3'd0);
  assign head      = mem_r[rd_r];
  assign room      = (cnt_r <= 3'd2);
  assign pop       = out_valid && out_ready;

  always_comb begin
    wr_nxt  = wr_r + push.cnt;
    rd_nxt  = rd_r + {1'b0, pop};
    cnt_nxt = cnt_r + {1'b0, push.cnt} - {2'b00, pop};
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem_r[wr_r] <= push.r0;
    end
    if (push.cnt == 2'd2) begin
      mem_r[wr_r + 2'd1] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/wav_stream_to_mono_pcm_top.sv =====
// Top level of the WAV byte stream to mono 16-bit PCM parser.
//
//   channel  direction  payload                                          handshake
//   in_      input      byte_value[7:0], last_byte                       in_valid / in_ready
//   out_     output     result_kind, sample_value, error_code, rate_hz,  out_valid / out_ready
//                       channel_count, sample_bits, last_of_run
//
// One byte is taken per cycle while in_ready is high; its results enter a four-entry queue
// in the same edge and, if the queue was empty, the first is offered on the next cycle.
// in_ready drops only while the queue holds three or more results, so a byte that
// yields two results never overflows it; a stalled consumer backs up into in_ready.
// Synchronous active-low reset returns the parser to the header phase and empties the queue.
module wav_stream_to_mono_pcm_top import wsm_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_byte_value,
  input  logic               in_last_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_result_kind,
  output logic signed [15:0] out_sample_value,
  output logic [3:0]         out_error_code,
  output logic [31:0]        out_rate_hz,
  output logic [15:0]        out_channel_count,
  output logic [15:0]        out_sample_bits,
  output logic               out_last_of_run
);

  push_t push;
  res_t  head;
  logic  room;
  logic  fire;

  assign in_ready = room;
  assign fire     = in_valid && room;

  wsm_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (fire),
    .byte_value (in_byte_value),
    .last_byte  (in_last_byte),
    .push       (push)
  );

  wsm_res_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign out_result_kind   = head.kind;
  assign out_sample_value  = head.sample;
  assign out_error_code    = head.err;
  assign out_rate_hz       = head.rate;
  assign out_channel_count = head.chans;
  assign out_sample_bits   = head.bits;
  assign out_last_of_run   = head.last;

endmodule

// ===== tb/wav_mono_checker.sv =====
// Scoreboard for the WAV parser: predicts the results of each accepted byte and checks them.
`timescale 1ns / 1ps
module wav_mono_checker import wsm_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [7:0]         in_byte_value,
  input  logic               in_last_byte,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [1:0]         out_result_kind,
  input  logic signed [15:0] out_sample_value,
  input  logic [3:0]         out_error_code,
  input  logic [31:0]        out_rate_hz,
  input  logic [15:0]        out_channel_count,
  input  logic [15:0]        out_sample_bits,
  input  logic               out_last_of_run,
  output int                 fail_count,
  output int                 results_waiting
);

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_CHUNK_HDR,
    PH_FMT_BODY,
    PH_SKIP,
    PH_DATA,
    PH_HOLD,
    PH_STOPPED
  } phase_t;

  localparam logic [1:0] CHUNK_OTHER = 2'd0;
  localparam logic [1:0] CHUNK_FMT   = 2'd1;
  localparam logic [1:0] CHUNK_DATA  = 2'd2;

  phase_t      phase;
  logic [5:0]  nbytes;
  logic [31:0] word_sr;
  logic [32:0] chunk_left;
  logic [1:0]  chunk_id;
  logic        fmt_seen;
  logic [15:0] fmt_tag;
  logic [15:0] fmt_chans;
  logic [31:0] fmt_rate;
  logic [15:0] fmt_align;
  logic [15:0] fmt_bits;
  logic [15:0] frame_pos;
  logic [7:0]  frame_buf [4];
  logic [3:0]  held_err;
  int          byte_nres;
  res_t        parser_results_q [$];

  function automatic void queue_result(kind_t k, logic [15:0] s, logic [3:0] e);
    res_t r;
    r = '0;
    r.kind = k;
    r.sample = s;
    r.err = e;
    if (k == KIND_INFO) begin
      r.rate  = fmt_rate;
      r.chans = fmt_chans;
      r.bits  = fmt_bits;
    end
    parser_results_q.push_back(r);
    byte_nres++;
  endfunction

  function automatic void clear_frame();
    frame_pos = 16'd0;
    foreach (frame_buf[i]) frame_buf[i] = 8'd0;
  endfunction

  function automatic void parser_error(logic [3:0] code);
    if (nbytes < MIN_BYTES) begin
      if (held_err == ERR_NONE) held_err = code;
      phase = PH_HOLD;
    end else begin
      queue_result(KIND_ERROR, 16'd0, code);
      phase = PH_STOPPED;
    end
  endfunction

  function automatic void parse_wav_byte(logic [7:0] b, logic last);
    int          idx;
    int          s;
    int          a;
    logic [15:0] smp;
    logic [31:0] size;
    res_t        r;
    byte_nres = 0;
    if (phase == PH_STOPPED) return;
    idx = int'(nbytes);
    if (nbytes < MIN_BYTES) nbytes++;

    case (phase)
      PH_HEADER: begin
        word_sr = {b, word_sr[31:8]};
        if (idx == 3 && word_sr != WORD_RIFF) begin
          parser_error(ERR_NO_RIFF);
        end else if (idx == 11) begin
          if (word_sr != WORD_WAVE) begin
            parser_error(ERR_NO_WAVE);
          end else begin
            phase = PH_CHUNK_HDR;
            frame_pos = 16'd0;
          end
        end
      end
      PH_CHUNK_HDR: begin
        word_sr = {b, word_sr[31:8]};
        frame_pos++;
        if (frame_pos == 16'd4) begin
          chunk_id = (word_sr == WORD_FMT) ? CHUNK_FMT :
                     (word_sr == WORD_DATA) ? CHUNK_DATA : CHUNK_OTHER;
        end else if (frame_pos >= 16'd8) begin
          size = word_sr;
          frame_pos = 16'd0;
          if (chunk_id == CHUNK_FMT) begin
            if (size < 32'(FMT_BODY)) begin
              parser_error(ERR_SMALL_FMT);
            end else begin
              fmt_seen = 1'b1;
              chunk_left = {1'b0, size} + 33'(size[0]);
              phase = PH_FMT_BODY;
            end
          end else if (chunk_id == CHUNK_DATA) begin
            if (!fmt_seen) begin
              parser_error(ERR_DATA_EARLY);
            end else if (fmt_tag != 16'd1) begin
              parser_error(ERR_NOT_PCM);
            end else if (fmt_align == 16'd0) begin
              parser_error(ERR_ZERO_ALIGN);
            end else begin
              queue_result(KIND_INFO, 16'd0, ERR_NONE);
              chunk_left = {1'b0, size};
              clear_frame();
              phase = PH_DATA;
              if (size == 32'd0 || last) begin
                queue_result(KIND_FINISH, 16'd0, ERR_NONE);
                phase = PH_STOPPED;
              end
            end
          end else begin
            chunk_left = {1'b0, size} + 33'(size[0]);
            phase = (chunk_left == 33'd0) ? PH_CHUNK_HDR : PH_SKIP;
          end
        end
      end
      PH_FMT_BODY: begin
        if (frame_pos < 16'd2) begin
          fmt_tag[{frame_pos[0], 3'b000} +: 8] = b;
        end else if (frame_pos < 16'd4) begin
          fmt_chans[{frame_pos[0], 3'b000} +: 8] = b;
        end else if (frame_pos < 16'd8) begin
          fmt_rate[{frame_pos[1:0], 3'b000} +: 8] = b;
        end else if (frame_pos >= 16'd12 && frame_pos < 16'd14) begin
          fmt_align[{frame_pos[0], 3'b000} +: 8] = b;
        end else if (frame_pos >= 16'd14 && frame_pos < 16'd16) begin
          fmt_bits[{frame_pos[0], 3'b000} +: 8] = b;
        end
        frame_pos++;
        chunk_left--;
        if (frame_pos >= FMT_BODY) begin
          frame_pos = 16'd0;
          phase = (chunk_left == 33'd0) ? PH_CHUNK_HDR : PH_SKIP;
        end
      end
      PH_SKIP: begin
        chunk_left--;
        if (chunk_left == 33'd0) begin
          frame_pos = 16'd0;
          phase = PH_CHUNK_HDR;
        end
      end
      PH_DATA: begin
        if (frame_pos < 16'd4) frame_buf[frame_pos[1:0]] = b;
        frame_pos++;
        chunk_left--;
        if (frame_pos == fmt_align) begin
          if (fmt_bits == 16'd16) begin
            if (fmt_chans >= 16'd2) begin
              s = int'($signed({frame_buf[1], frame_buf[0]})) +
                  int'($signed({frame_buf[3], frame_buf[2]}));
              smp = 16'(s >>> 1);
            end else begin
              smp = {frame_buf[1], frame_buf[0]};
            end
          end else begin
            a = (fmt_chans >= 16'd2) ? (int'(frame_buf[0]) + int'(frame_buf[1])) / 2
                                      : int'(frame_buf[0]);
            smp = 16'((a - 128) * 256);
          end
          queue_result(KIND_SAMPLE, smp, ERR_NONE);
          clear_frame();
        end
        if (chunk_left == 33'd0 || last) begin
          queue_result(KIND_FINISH, 16'd0, ERR_NONE);
          phase = PH_STOPPED;
        end
      end
      default: ;
    endcase

    if (phase == PH_HOLD && nbytes >= MIN_BYTES) begin
      queue_result(KIND_ERROR, 16'd0, held_err);
      phase = PH_STOPPED;
    end else if (last && phase != PH_STOPPED) begin
      if (nbytes < MIN_BYTES) queue_result(KIND_ERROR, 16'd0, ERR_SHORT);
      else if (phase == PH_DATA) queue_result(KIND_FINISH, 16'd0, ERR_NONE);
      else queue_result(KIND_ERROR, 16'd0, ERR_NO_DATA);
      phase = PH_STOPPED;
    end

    if (byte_nres > 0) begin
      r = parser_results_q.pop_back();
      r.last = 1'b1;
      parser_results_q.push_back(r);
    end
  endfunction

  always @(posedge clk) begin
    res_t got;
    if (!rst_n) begin
      phase = PH_HEADER;
      nbytes = 6'd0;
      word_sr = 32'd0;
      chunk_left = 33'd0;
      chunk_id = CHUNK_OTHER;
      fmt_seen = 1'b0;
      fmt_tag = 16'd0;
      fmt_chans = 16'd0;
      fmt_rate = 32'd0;
      fmt_align = 16'd0;
      fmt_bits = 16'd0;
      held_err = ERR_NONE;
      clear_frame();
      parser_results_q.delete();
      fail_count = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (parser_results_q.size() == 0) begin
          $error("unexpected result transfer: kind %0d", out_result_kind);
          fail_count++;
        end else begin
          got = parser_results_q.pop_front();
          if (out_result_kind !== got.kind) begin
            $error("result_kind: expected %0d, got %0d", got.kind, out_result_kind);
            fail_count++;
          end
          if (out_sample_value !== got.sample) begin
            $error("sample_value: expected %0d, got %0d", got.sample, out_sample_value);
            fail_count++;
          end
          if (out_error_code !== got.err) begin
            $error("error_code: expected %0d, got %0d", got.err, out_error_code);
            fail_count++;
          end
          if (out_rate_hz !== got.rate) begin
            $error("rate_hz: expected %0d, got %0d", got.rate, out_rate_hz);
            fail_count++;
          end
          if (out_channel_count !== got.chans) begin
            $error("channel_count: expected %0d, got %0d", got.chans, out_channel_count);
            fail_count++;
          end
          if (out_sample_bits !== got.bits) begin
            $error("sample_bits: expected %0d, got %0d", got.bits, out_sample_bits);
            fail_count++;
          end
          if (out_last_of_run !== got.last) begin
            $error("last_of_run: expected %0d, got %0d", got.last, out_last_of_run);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) parse_wav_byte(in_byte_value, in_last_byte);
    end
    results_waiting = parser_results_q.size();
  end

endmodule

// ===== tb/wav_stream_to_mono_pcm_top_tb.sv =====
// Testbench top for the WAV parser: builds a byte stream, drives both channels, reports.
`timescale 1ns / 1ps
module wav_stream_to_mono_pcm_top_tb;
  import wsm_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 20;
  localparam int MIN_STREAM  = 450;
  localparam logic [7:0] EXTREME_BYTES [12] = '{
    8'h00, 8'h80, 8'h00, 8'h80, 8'hFF, 8'h7F, 8'hFF, 8'h7F, 8'hFF, 8'hFF, 8'h00, 8'h00
  };

  typedef struct packed {
    logic [7:0] val;
    logic       last;
  } wav_byte_t;

  typedef enum int {
    FAULT_NONE,
    FAULT_RIFF,
    FAULT_WAVE,
    FAULT_SMALL_FMT,
    FAULT_DATA_FIRST,
    FAULT_NO_DATA,
    FAULT_NOT_PCM,
    FAULT_ZERO_ALIGN,
    FAULT_SHORT,
    FAULT_HUGE_SKIP
  } fault_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [7:0]         in_byte_value;
  logic               in_last_byte;
  logic               out_valid;
  logic               out_ready;
  logic [1:0]         out_result_kind;
  logic signed [15:0] out_sample_value;
  logic [3:0]         out_error_code;
  logic [31:0]        out_rate_hz;
  logic [15:0]        out_channel_count;
  logic [15:0]        out_sample_bits;
  logic               out_last_of_run;

  int        fail_count;
  int        results_waiting;
  int        sent_count = 0;
  int        hold_at = 0;
  int        cycle_count = 0;
  wav_byte_t wav_q [$];

  wav_stream_to_mono_pcm_top dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_byte_value     (in_byte_value),
    .in_last_byte      (in_last_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_result_kind   (out_result_kind),
    .out_sample_value  (out_sample_value),
    .out_error_code    (out_error_code),
    .out_rate_hz       (out_rate_hz),
    .out_channel_count (out_channel_count),
    .out_sample_bits   (out_sample_bits),
    .out_last_of_run   (out_last_of_run)
  );

  wav_mono_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_byte_value     (in_byte_value),
    .in_last_byte      (in_last_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_result_kind   (out_result_kind),
    .out_sample_value  (out_sample_value),
    .out_error_code    (out_error_code),
    .out_rate_hz       (out_rate_hz),
    .out_channel_count (out_channel_count),
    .out_sample_bits   (out_sample_bits),
    .out_last_of_run   (out_last_of_run),
    .fail_count        (fail_count),
    .results_waiting   (results_waiting)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** wav_stream_to_mono_pcm_top: FAILED **");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int pick_idle_pct();
    case ($urandom_range(0, 3))
      0, 1: return 0;
      2: return 15;
      default: return 45;
    endcase
  endfunction

  task automatic put_byte(input logic [7:0] b);
    wav_q.push_back('{val: b, last: 1'b0});
  endtask

  task automatic put_half(input logic [15:0] h);
    put_byte(h[7:0]);
    put_byte(h[15:8]);
  endtask

  task automatic put_word(input logic [31:0] w);
    put_half(w[15:0]);
    put_half(w[31:16]);
  endtask

  task automatic put_skip_chunk();
    logic [31:0] size;
    size = ($urandom_range(0, 3) == 0) ? 32'd0 : 32'($urandom_range(1, 9));
    put_word($urandom());
    put_word(size);
    repeat (size + size[0]) put_byte(8'($urandom()));
  endtask

  task automatic build_wav_stream();
    fault_t      fault;
    logic [15:0] tag;
    logic [15:0] chans;
    logic [15:0] bits;
    logic [15:0] align;
    logic [31:0] rate;
    logic [31:0] fmt_size;
    logic [31:0] pcm_len;
    int          n_data;
    int          end_mode;
    int          cut;
    if ($urandom_range(0, 99) < 70) fault = FAULT_NONE;
    else fault = fault_t'($urandom_range(int'(FAULT_RIFF), int'(FAULT_HUGE_SKIP)));
    hold_at = 20;

    put_word(fault == FAULT_RIFF ? WORD_RIFF ^ (32'd1 << $urandom_range(0, 31)) : WORD_RIFF);
    put_word($urandom());
    put_word(fault == FAULT_WAVE ? WORD_WAVE ^ (32'd1 << $urandom_range(0, 31)) : WORD_WAVE);
    if (fault == FAULT_DATA_FIRST) begin
      put_word(WORD_DATA);
      put_word(32'($urandom_range(0, 64)));
    end
    repeat ($urandom_range(0, 2)) put_skip_chunk();

    tag = 16'd1;
    if (fault == FAULT_NOT_PCM) tag = $urandom_range(0, 1) ? 16'd0 : 16'($urandom_range(2, 65535));
    case ($urandom_range(0, 9))
      0: chans = 16'd0;
      1: chans = 16'd3;
      2: chans = 16'hFFFF;
      3, 4, 5: chans = 16'd1;
      default: chans = 16'd2;
    endcase
    case ($urandom_range(0, 9))
      0, 1, 2, 3: bits = 16'd16;
      4, 5, 6, 7: bits = 16'd8;
      default: bits = 16'($urandom());
    endcase
    if (fault == FAULT_ZERO_ALIGN) align = 16'd0;
    else if ($urandom_range(0, 3) == 0) align = 16'($urandom_range(1, 6));
    else align = 16'(((bits == 16'd16) ? 2 : 1) * ((chans >= 16'd2) ? 2 : 1));
    case ($urandom_range(0, 7))
      0: rate = 32'd0;
      1: rate = 32'hFFFF_FFFF;
      default: rate = $urandom();
    endcase
    if (fault == FAULT_SMALL_FMT) fmt_size = 32'($urandom_range(0, 15));
    else fmt_size = 32'd16 + (($urandom_range(0, 3) == 0) ? 32'($urandom_range(1, 5)) : 32'd0);

    put_word(WORD_FMT);
    put_word(fmt_size);
    put_half(tag);
    put_half(chans);
    put_word(rate);
    put_word($urandom());
    put_half(align);
    put_half(bits);
    if (fmt_size > 32'd16) repeat (fmt_size - 32'd16 + fmt_size[0]) put_byte(8'($urandom()));
    if ($urandom_range(0, 1) == 1) put_skip_chunk();
    if (fault == FAULT_HUGE_SKIP) begin
      put_word($urandom());
      put_word(32'hFFFF_FFFF);
    end

    if (fault != FAULT_NO_DATA) begin
      n_data = $urandom_range(360, 440);
      end_mode = $urandom_range(0, 19);
      if (end_mode == 0) pcm_len = 32'd0;
      else if (end_mode < 14) pcm_len = 32'(n_data);
      else if (end_mode < 17) pcm_len = 32'(n_data + $urandom_range(1, 100));
      else pcm_len = 32'hFFFF_FFFF;
      put_word(WORD_DATA);
      put_word(pcm_len);
      hold_at = wav_q.size() + 8;
      for (int i = 0; i < n_data; i++) put_byte(i < 12 ? EXTREME_BYTES[i] : 8'($urandom()));
      if (end_mode >= 11 && end_mode < 14) repeat ($urandom_range(1, 6)) put_byte(8'($urandom()));
    end

    if (fault == FAULT_SHORT) begin
      cut = $urandom_range(1, 43);
      while (wav_q.size() > cut) void'(wav_q.pop_back());
    end
    wav_q[wav_q.size() - 1].last = 1'b1;
    // trailing bytes after the end of the file
    repeat (6) wav_q.push_back('{val: 8'($urandom()), last: 1'($urandom())});
    while (wav_q.size() < MIN_STREAM)
      wav_q.push_back('{val: 8'($urandom()), last: 1'($urandom())});
    if (hold_at > wav_q.size()) hold_at = wav_q.size();
  endtask

  task automatic feed_bytes();
    int idle_pct;
    int gap;
    idle_pct = 0;
    @(negedge clk);
    for (int i = 0; i < wav_q.size(); i++) begin
      if (i % 64 == 0) idle_pct = pick_idle_pct();
      gap = ($urandom_range(0, 99) < idle_pct) ? pick_gap() : 0;
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      in_valid      <= 1'b1;
      in_byte_value <= wav_q[i].val;
      in_last_byte  <= wav_q[i].last;
      do @(posedge clk); while (!in_ready);
      sent_count++;
      @(negedge clk);
    end
    in_valid <= 1'b0;
  endtask

  initial begin : drain
    int  stall_left;
    int  stall_pct;
    int  cyc;
    bit  held;
    out_ready  = 1'b0;
    stall_left = 0;
    stall_pct  = 0;
    cyc        = 0;
    held       = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (cyc % 64 == 0) stall_pct = pick_idle_pct();
      cyc++;
      if (!held && sent_count >= hold_at) begin
        // hold off long enough for the result queue to fill and block the input
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if ($urandom_range(0, 99) < stall_pct) begin
        stall_left = pick_gap() - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_byte_value = 8'd0;
    in_last_byte  = 1'b0;
    build_wav_stream();
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    feed_bytes();
    wait (results_waiting == 0);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("** wav_stream_to_mono_pcm_top: PASSED **");
    end else begin
      $display("** wav_stream_to_mono_pcm_top: FAILED **");
    end
    $finish;
  end

endmodule
